// ===== hdl/evq_pkg.sv =====
// ----------------------------------------------------------------------------
// evq_pkg
// Shared types and codes for the event queue dispatcher: commands, event
// kinds, result status codes, queue entry layouts and ring handshake structs.
// ----------------------------------------------------------------------------
package evq_pkg;

	localparam int ASYNC_DEPTH_DEF = 16;
	localparam int PAGE_DEPTH_DEF  = 8;

	typedef enum logic [1:0] {
		CMD_EVENT      = 2'd0,
		CMD_POP_ASYNC  = 2'd1,
		CMD_POP_PAGE   = 2'd2,
		CMD_PAGE_DONE  = 2'd3
	} cmd_t;

	// event kinds arriving with an event command
	localparam logic [2:0] KIND_COMPLETION = 3'd0;
	localparam logic [2:0] KIND_PAGE_REQ   = 3'd1;
	localparam logic [2:0] KIND_PORT_CHG   = 3'd2;
	localparam logic [2:0] KIND_DEV_FATAL  = 3'd3;
	localparam logic [2:0] KIND_WQ_CATAS   = 3'd4;
	localparam logic [2:0] KIND_OTHER      = 3'd5;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_OVERFLOW   = 3'd2,
		ST_ZERO       = 3'd3,
		ST_COALESCED  = 3'd4,
		ST_IGNORED    = 3'd5,
		ST_ASYNC_FULL = 3'd6
	} status_t;

	// async event kinds and elements
	localparam logic [1:0] AKIND_PORT_ACTIVE = 2'd0;
	localparam logic [1:0] AKIND_DEV_FATAL   = 2'd1;
	localparam logic [1:0] AKIND_WQ_FATAL    = 2'd2;
	localparam logic       ELEM_PORT         = 1'b0;
	localparam logic       ELEM_DEVICE       = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic       element;
		logic [3:0] handle;
	} async_entry_t;

	typedef struct packed {
		logic [15:0] func;
		logic [31:0] count;
	} page_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

endpackage

// ===== hdl/evq_ring.sv =====
// ----------------------------------------------------------------------------
// evq_ring
// Circular queue holding DEPTH-1 entries. Storage is a memory with one write
// port and one registered read port; the read register loads on a pop and
// holds otherwise.
// ----------------------------------------------------------------------------
module evq_ring #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  evq_pkg::ring_ctrl_t ctrl,
	input  logic [WIDTH-1:0]    wdata,
	output logic [WIDTH-1:0]    rdata,
	output evq_pkg::ring_stat_t stat
);
	import evq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW-1:0]    wr_nxt;
	logic [PW-1:0]    rd_nxt;

	assign wr_nxt = (wr_q == LAST) ? '0 : wr_q + 1'b1;
	assign rd_nxt = (rd_q == LAST) ? '0 : rd_q + 1'b1;

	assign stat.full  = (wr_nxt == rd_q);
	assign stat.empty = (wr_q == rd_q);
	assign rdata      = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (ctrl.push) begin
				wr_q <= wr_nxt;
			end
			if (ctrl.pop) begin
				rd_q <= rd_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_q] <= wdata;
		end
		if (ctrl.pop) begin
			rdata_q <= mem[rd_q];
		end
	end

endmodule

// ===== hdl/event_queue_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// event_queue_dispatcher_core
// Event dispatcher with an async event ring, a page request ring, an active
// page request and a sticky health error latch.
// ----------------------------------------------------------------------------
// One word is taken per clock while rsp_ready is high, and every word gives
// exactly one result word. A word is registered on entry, decoded against the
// queue state by the single decode stage, and its result is registered with
// the queue and latch updates; a stall on rsp_ready holds the word in the
// input register until the result register can advance. The async ring keeps
// ASYNC_DEPTH-1 events and the page ring PAGE_DEPTH-1 requests; queue storage
// has no reset and needs no clearing pass. The active page request is the last
// entry read from the page ring. health_failed is sticky until reset.
module event_queue_dispatcher_core #(
	parameter int ASYNC_DEPTH = evq_pkg::ASYNC_DEPTH_DEF,
	parameter int PAGE_DEPTH  = evq_pkg::PAGE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         cmd,
	input  logic [2:0]         event_kind,
	input  logic [23:0]        cq_id,
	input  logic [15:0]        fn_id,
	input  logic signed [31:0] page_count,
	input  logic [3:0]         port_number,
	input  logic               handler_failed,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         status,
	output logic               completion_valid,
	output logic [23:0]        completion_cq,
	output logic               fatal_mark,
	output logic               async_valid,
	output logic [1:0]         async_kind,
	output logic               async_element,
	output logic [3:0]         async_handle,
	output logic               page_valid,
	output logic [15:0]        page_function,
	output logic signed [31:0] page_amount,
	output logic               health_failed
);
	import evq_pkg::*;

	// input register
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [2:0]  kind_s1;
	logic [23:0] cq_s1;
	logic [15:0] func_s1;
	logic [31:0] count_s1;
	logic [3:0]  port_s1;
	logic        failed_s1;

	// result register
	logic        rsp_valid_q;
	status_t     status_s2;
	logic        comp_valid_s2;
	logic [23:0] comp_cq_s2;
	logic        fatal_s2;
	logic        avalid_s2;
	logic        pvalid_s2;

	logic        active_busy_q;
	logic        error_q;

	logic        adv;
	logic        go;

	ring_ctrl_t   actl;
	ring_ctrl_t   pctl;
	ring_stat_t   astat;
	ring_stat_t   pstat;
	async_entry_t awdata;
	async_entry_t ardata;
	page_entry_t  pwdata;
	page_entry_t  prdata;

	status_t     st;
	logic        comp_v;
	logic        fatal;
	logic        apush;
	logic        apop;
	logic        ppush;
	logic        ppop;
	logic        err_set;
	logic        busy_nxt;
	logic        coalesce;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || adv;
	assign go        = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1    <= cmd_t'(cmd);
			kind_s1   <= event_kind;
			cq_s1     <= cq_id;
			func_s1   <= fn_id;
			count_s1  <= page_count;
			port_s1   <= port_number;
			failed_s1 <= handler_failed;
		end
	end

	// active request matches on function and sign
	assign coalesce = active_busy_q && (func_s1 == prdata.func)
		&& (count_s1[31] == prdata.count[31]);

	always_comb begin
		st       = ST_DONE;
		comp_v   = 1'b0;
		fatal    = 1'b0;
		apush    = 1'b0;
		apop     = 1'b0;
		ppush    = 1'b0;
		ppop     = 1'b0;
		err_set  = 1'b0;
		busy_nxt = active_busy_q;
		awdata   = '{kind: AKIND_PORT_ACTIVE, element: ELEM_PORT,
			handle: (port_s1 != 4'd0) ? port_s1 : 4'd1};
		case (cmd_s1)
			CMD_EVENT: begin
				case (kind_s1)
					KIND_COMPLETION: begin
						comp_v = 1'b1;
					end
					KIND_PAGE_REQ: begin
						if (count_s1 == '0) begin
							err_set = 1'b1;
							st      = ST_ZERO;
						end else if (coalesce) begin
							st = ST_COALESCED;
						end else if (pstat.full) begin
							err_set = 1'b1;
							st      = ST_OVERFLOW;
						end else begin
							ppush = 1'b1;
						end
					end
					KIND_PORT_CHG: begin
						if (astat.full) begin
							st = ST_ASYNC_FULL;
						end else begin
							apush = 1'b1;
						end
					end
					KIND_DEV_FATAL, KIND_WQ_CATAS: begin
						fatal  = 1'b1;
						awdata = '{kind: (kind_s1 == KIND_DEV_FATAL) ?
							AKIND_DEV_FATAL : AKIND_WQ_FATAL,
							element: ELEM_DEVICE, handle: 4'd0};
						if (astat.full) begin
							st = ST_ASYNC_FULL;
						end else begin
							apush = 1'b1;
						end
					end
					default: begin
						st = ST_IGNORED;
					end
				endcase
			end
			CMD_POP_ASYNC: begin
				if (astat.empty) begin
					st = ST_EMPTY;
				end else begin
					apop = 1'b1;
				end
			end
			CMD_POP_PAGE: begin
				if (pstat.empty) begin
					st = ST_EMPTY;
				end else begin
					ppop     = 1'b1;
					busy_nxt = 1'b1;
				end
			end
			CMD_PAGE_DONE: begin
				if (!active_busy_q) begin
					st = ST_IGNORED;
				end else begin
					busy_nxt = 1'b0;
					err_set  = failed_s1;
				end
			end
			default: begin
				st = ST_IGNORED;
			end
		endcase
	end

	assign pwdata = '{func: func_s1, count: count_s1};

	assign actl.push = go && apush;
	assign actl.pop  = go && apop;
	assign pctl.push = go && ppush;
	assign pctl.pop  = go && ppop;

	evq_ring #(
		.DEPTH (ASYNC_DEPTH),
		.WIDTH ($bits(async_entry_t))
	) u_async_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (actl),
		.wdata  (awdata),
		.rdata  (ardata),
		.stat   (astat)
	);

	evq_ring #(
		.DEPTH (PAGE_DEPTH),
		.WIDTH ($bits(page_entry_t))
	) u_page_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pctl),
		.wdata  (pwdata),
		.rdata  (prdata),
		.stat   (pstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q   <= 1'b0;
			active_busy_q <= 1'b0;
			error_q       <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				active_busy_q <= busy_nxt;
				error_q       <= error_q | err_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_s2     <= st;
			comp_valid_s2 <= comp_v;
			comp_cq_s2    <= comp_v ? cq_s1 : '0;
			fatal_s2      <= fatal;
			avalid_s2     <= apop;
			pvalid_s2     <= ppop;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign status           = status_s2;
	assign completion_valid = comp_valid_s2;
	assign completion_cq    = comp_cq_s2;
	assign fatal_mark       = fatal_s2;
	assign async_valid      = avalid_s2;
	assign async_kind       = avalid_s2 ? ardata.kind : '0;
	assign async_element    = avalid_s2 ? ardata.element : 1'b0;
	assign async_handle     = avalid_s2 ? ardata.handle : '0;
	assign page_valid       = pvalid_s2;
	assign page_function    = pvalid_s2 ? prdata.func : '0;
	assign page_amount      = pvalid_s2 ? $signed(prdata.count) : '0;
	assign health_failed    = error_q;

	a_latch_sticky : assert property (@(posedge clk) disable iff (!arst_n)
		error_q |=> error_q)
		else $error("health latch cleared without reset");

	a_ring_one_op : assert property (@(posedge clk) disable iff (!arst_n)
		!((actl.push || actl.pop) && (pctl.push || pctl.pop)) && !(actl.push && actl.pop)
		&& !(pctl.push && pctl.pop))
		else $error("more than one ring operation in a cycle");

	a_fatal_status : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && fatal_s2 |-> (status_s2 == ST_DONE || status_s2 == ST_ASYNC_FULL))
		else $error("fatal mark with unexpected status");

	a_page_pop_busy : assert property (@(posedge clk) disable iff (!arst_n)
		pctl.pop |=> active_busy_q && pvalid_s2 && rsp_valid_q)
		else $error("page pop did not make request active");

endmodule

// ===== dv/event_queue_dispatcher_core_test.sv =====
// ----------------------------------------------------------------------------
// event_queue_dispatcher_core_test
// Self-checking bench for the event queue dispatcher. A queue of request words
// (a short directed opening, then random segments that fill, drain or mix
// both rings, at random) feeds a valid/ready driver. Each accepted word runs
// through a local model of the rings, the active page request and the health
// latch. The monitor checks every result word field by field, in order.
// ----------------------------------------------------------------------------
module event_queue_dispatcher_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import evq_pkg::*;

	localparam int ASYNC_SLOTS = ASYNC_DEPTH_DEF;
	localparam int PAGE_SLOTS = PAGE_DEPTH_DEF;
	localparam int RANDOM_WORDS = 450;
	localparam int SEGMENT_LEN = 25;
	localparam int QUIET_TAIL = 60;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP = 30;

	typedef struct packed {
		cmd_t               cmd;
		logic [2:0]         kind;
		logic [23:0]        cq;
		logic [15:0]        func;
		logic signed [31:0] count;
		logic [3:0]         port;
		logic               failed;
	} req_word_t;

	typedef struct packed {
		status_t            status;
		logic               cpl_valid;
		logic [23:0]        cpl_cq;
		logic               fatal;
		logic               av;
		logic [1:0]         akind;
		logic               aelem;
		logic [3:0]         ahandle;
		logic               pv;
		logic [15:0]        pfunc;
		logic signed [31:0] pamount;
		logic               health;
	} rsp_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [1:0]         cmd = '0;
	logic [2:0]         event_kind = '0;
	logic [23:0]        cq_id = '0;
	logic [15:0]        fn_id = '0;
	logic signed [31:0] page_count = '0;
	logic [3:0]         port_number = '0;
	logic               handler_failed = 1'b0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [2:0]         status;
	logic               completion_valid;
	logic [23:0]        completion_cq;
	logic               fatal_mark;
	logic               async_valid;
	logic [1:0]         async_kind;
	logic               async_element;
	logic [3:0]         async_handle;
	logic               page_valid;
	logic [15:0]        page_function;
	logic signed [31:0] page_amount;
	logic               health_failed;

	event_queue_dispatcher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.event_kind(event_kind),
		.cq_id(cq_id),
		.fn_id(fn_id),
		.page_count(page_count),
		.port_number(port_number),
		.handler_failed(handler_failed),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.completion_valid(completion_valid),
		.completion_cq(completion_cq),
		.fatal_mark(fatal_mark),
		.async_valid(async_valid),
		.async_kind(async_kind),
		.async_element(async_element),
		.async_handle(async_handle),
		.page_valid(page_valid),
		.page_function(page_function),
		.page_amount(page_amount),
		.health_failed(health_failed)
	);

	req_word_t pending_words[$];
	rsp_word_t expected_results[$];
	req_word_t head_word;
	int total_words = 0;
	int words_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int hold_cycles = 0;
	bit long_hold_done = 1'b0;
	int status_hits [0:7];

	// dispatcher state as the bench sees it
	async_entry_t async_slots [ASYNC_SLOTS];
	page_entry_t  page_slots [PAGE_SLOTS];
	int as_wr = 0, as_rd = 0, pg_wr = 0, pg_rd = 0;
	logic act_busy = 1'b0;
	logic [15:0] act_func = '0;
	logic act_neg = 1'b0;
	logic health_latch = 1'b0;

	task automatic dispatch_word(input req_word_t w);
		rsp_word_t r;
		async_entry_t e;
		page_entry_t p;
		r = '0;
		r.status = ST_DONE;
		e = '0;
		case (w.cmd)
			CMD_EVENT: begin
				case (w.kind)
					KIND_COMPLETION: begin
						r.cpl_valid = 1'b1;
						r.cpl_cq = w.cq;
					end
					KIND_PAGE_REQ: begin
						if (w.count == 0) begin
							health_latch = 1'b1;
							r.status = ST_ZERO;
						end else if (act_busy && w.func == act_func && w.count[31] == act_neg) begin
							r.status = ST_COALESCED;
						end else if ((pg_wr + 1) % PAGE_SLOTS == pg_rd) begin
							health_latch = 1'b1;
							r.status = ST_OVERFLOW;
						end else begin
							page_slots[pg_wr] = {w.func, w.count};
							pg_wr = (pg_wr + 1) % PAGE_SLOTS;
						end
					end
					KIND_PORT_CHG, KIND_DEV_FATAL, KIND_WQ_CATAS: begin
						if (w.kind == KIND_PORT_CHG) begin
							e.kind = AKIND_PORT_ACTIVE;
							e.element = ELEM_PORT;
							// port 0 is reported as port 1
							e.handle = (w.port != 0) ? w.port : 4'd1;
						end else begin
							r.fatal = 1'b1;
							e.kind = (w.kind == KIND_DEV_FATAL) ? AKIND_DEV_FATAL : AKIND_WQ_FATAL;
							e.element = ELEM_DEVICE;
							e.handle = '0;
						end
						if ((as_wr + 1) % ASYNC_SLOTS == as_rd) begin
							r.status = ST_ASYNC_FULL;
						end else begin
							async_slots[as_wr] = e;
							as_wr = (as_wr + 1) % ASYNC_SLOTS;
						end
					end
					default: r.status = ST_IGNORED;
				endcase
			end
			CMD_POP_ASYNC: begin
				if (as_rd == as_wr) begin
					r.status = ST_EMPTY;
				end else begin
					e = async_slots[as_rd];
					as_rd = (as_rd + 1) % ASYNC_SLOTS;
					r.av = 1'b1;
					r.akind = e.kind;
					r.aelem = e.element;
					r.ahandle = e.handle;
				end
			end
			CMD_POP_PAGE: begin
				if (pg_rd == pg_wr) begin
					r.status = ST_EMPTY;
				end else begin
					// a pop while active simply replaces the active request
					p = page_slots[pg_rd];
					pg_rd = (pg_rd + 1) % PAGE_SLOTS;
					act_busy = 1'b1;
					act_func = p.func;
					act_neg = p.count[31];
					r.pv = 1'b1;
					r.pfunc = p.func;
					r.pamount = p.count;
				end
			end
			CMD_PAGE_DONE: begin
				if (!act_busy) begin
					r.status = ST_IGNORED;
				end else begin
					act_busy = 1'b0;
					act_func = '0;
					act_neg = 1'b0;
					if (w.failed)
						health_latch = 1'b1;
				end
			end
		endcase
		r.health = health_latch;
		status_hits[r.status]++;
		expected_results.push_back(r);
	endtask

	task automatic add_word(input cmd_t c, input logic [2:0] k, input logic [23:0] q,
			input logic [15:0] f, input logic [31:0] n, input logic [3:0] pt, input logic hf);
		req_word_t w;
		w.cmd = c;
		w.kind = k;
		w.cq = q;
		w.func = f;
		w.count = n;
		w.port = pt;
		w.failed = hf;
		pending_words.push_back(w);
	endtask

	// mode 0 fills the rings, mode 1 drains them, mode 2 is an even mix
	function automatic req_word_t random_word(input int mode);
		req_word_t w;
		int r;
		w.cq = 24'($urandom);
		w.port = 4'($urandom);
		w.failed = 1'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 2))
				0: w.func = 16'h0000;
				1: w.func = 16'hffff;
				default: w.func = 16'h00a5;
			endcase
		end else begin
			w.func = 16'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			w.count = 0;
		end else if (r < 10) begin
			case ($urandom_range(0, 3))
				0: w.count = 32'h7fffffff;
				1: w.count = 32'h80000000;
				2: w.count = 1;
				default: w.count = -1;
			endcase
		end else begin
			w.count = $urandom;
			if (w.count == 0)
				w.count = 1;
		end
		r = $urandom_range(0, 99);
		if (r < 20)
			w.kind = KIND_COMPLETION;
		else if (r < 55)
			w.kind = KIND_PAGE_REQ;
		else if (r < 75)
			w.kind = KIND_PORT_CHG;
		else if (r < 85)
			w.kind = KIND_DEV_FATAL;
		else if (r < 95)
			w.kind = KIND_WQ_CATAS;
		else
			w.kind = KIND_OTHER + 3'($urandom_range(0, 2));
		r = $urandom_range(0, 99);
		case (mode)
			0: w.cmd = (r < 85) ? CMD_EVENT : (r < 90) ? CMD_POP_ASYNC :
				(r < 95) ? CMD_POP_PAGE : CMD_PAGE_DONE;
			1: w.cmd = (r < 20) ? CMD_EVENT : (r < 50) ? CMD_POP_ASYNC :
				(r < 80) ? CMD_POP_PAGE : CMD_PAGE_DONE;
			default: w.cmd = (r < 50) ? CMD_EVENT : (r < 65) ? CMD_POP_ASYNC :
				(r < 80) ? CMD_POP_PAGE : CMD_PAGE_DONE;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got 0x%0h expected 0x%0h",
				results_seen, name, got, want));
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int mode;
		foreach (status_hits[i])
			status_hits[i] = 0;
		// directed opening: empty queues, extremes, every event kind
		add_word(CMD_POP_ASYNC, KIND_COMPLETION, '0, '0, 0, '0, 1'b0);
		add_word(CMD_POP_PAGE, KIND_COMPLETION, '0, '0, 0, '0, 1'b0);
		add_word(CMD_PAGE_DONE, KIND_COMPLETION, '0, '0, 0, '0, 1'b1);
		add_word(CMD_EVENT, KIND_COMPLETION, 24'hffffff, '0, 0, '0, 1'b0);
		add_word(CMD_EVENT, KIND_COMPLETION, 24'h000000, 16'hffff, -1, 4'hf, 1'b1);
		add_word(CMD_EVENT, KIND_OTHER, 24'h123456, '0, 0, '0, 1'b0);
		add_word(CMD_EVENT, 3'd7, '0, '0, 0, '0, 1'b0);
		add_word(CMD_EVENT, KIND_PORT_CHG, '0, '0, 0, 4'd0, 1'b0);
		add_word(CMD_EVENT, KIND_PORT_CHG, '0, '0, 0, 4'd15, 1'b0);
		add_word(CMD_EVENT, KIND_DEV_FATAL, '0, '0, 0, 4'd7, 1'b0);
		add_word(CMD_EVENT, KIND_WQ_CATAS, '0, '0, 0, '0, 1'b0);
		repeat (4)
			add_word(CMD_POP_ASYNC, KIND_COMPLETION, '0, '0, 0, '0, 1'b0);
		add_word(CMD_EVENT, KIND_PAGE_REQ, '0, 16'hffff, 32'h7fffffff, '0, 1'b0);
		add_word(CMD_EVENT, KIND_PAGE_REQ, '0, 16'h0000, 32'h80000000, '0, 1'b0);
		add_word(CMD_POP_PAGE, KIND_COMPLETION, '0, '0, 0, '0, 1'b0);
		// same function and sign as the active request: merged
		add_word(CMD_EVENT, KIND_PAGE_REQ, '0, 16'hffff, 5, '0, 1'b0);
		add_word(CMD_EVENT, KIND_PAGE_REQ, '0, 16'hffff, -1, '0, 1'b0);
		add_word(CMD_PAGE_DONE, KIND_COMPLETION, '0, '0, 0, '0, 1'b0);
		add_word(CMD_POP_PAGE, KIND_COMPLETION, '0, '0, 0, '0, 1'b0);
		add_word(CMD_PAGE_DONE, KIND_COMPLETION, '0, '0, 0, '0, 1'b1);
		add_word(CMD_EVENT, KIND_PAGE_REQ, '0, 16'h1234, 0, '0, 1'b0);
		mode = 0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % SEGMENT_LEN == 0)
				mode = $urandom_range(0, 2);
			pending_words.push_back(random_word(mode));
		end
		total_words = pending_words.size();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!(words_sent == total_words && expected_results.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("ran %0d words: %0d async ring full, %0d page overflows, %0d coalesced",
			total_words, status_hits[ST_ASYNC_FULL], status_hits[ST_OVERFLOW],
			status_hits[ST_COALESCED]);
		$display("%0d zero-count requests, %0d empty pops, %0d ignored, %0d mismatches",
			status_hits[ST_ZERO], status_hits[ST_EMPTY], status_hits[ST_IGNORED], mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("event_queue_dispatcher_core_test: PASS");
		else
			$display("event_queue_dispatcher_core_test: FAIL");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				dispatch_word(head_word);
				words_sent <= words_sent + 1;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					req_valid <= 1'b0;
				end else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(0, 18);
					req_valid <= 1'b0;
				end else begin
					head_word = pending_words.pop_front();
					cmd <= head_word.cmd;
					event_kind <= head_word.kind;
					cq_id <= head_word.cq;
					fn_id <= head_word.func;
					page_count <= head_word.count;
					port_number <= head_word.port;
					handler_failed <= head_word.failed;
					req_valid <= 1'b1;
				end
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_ready <= 1'b0;
			end else if (!long_hold_done && words_sent >= 120) begin
				long_hold_done = 1'b1;
				hold_cycles = LONG_HOLD;
				rsp_ready <= 1'b0;
			end else if (words_sent + QUIET_TAIL < total_words && $urandom_range(0, 11) == 0) begin
				hold_cycles = $urandom_range(0, 18);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("word %0d arrived with nothing expected", results_seen));
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(status), 32'(want.status));
				check_field("completion_valid", 32'(completion_valid), 32'(want.cpl_valid));
				check_field("completion_cq", 32'(completion_cq), 32'(want.cpl_cq));
				check_field("fatal_mark", 32'(fatal_mark), 32'(want.fatal));
				check_field("async_valid", 32'(async_valid), 32'(want.av));
				check_field("async_kind", 32'(async_kind), 32'(want.akind));
				check_field("async_element", 32'(async_element), 32'(want.aelem));
				check_field("async_handle", 32'(async_handle), 32'(want.ahandle));
				check_field("page_valid", 32'(page_valid), 32'(want.pv));
				check_field("page_function", 32'(page_function), 32'(want.pfunc));
				check_field("page_amount", page_amount, want.pamount);
				check_field("health_failed", 32'(health_failed), 32'(want.health));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_results.size());
			$display("event_queue_dispatcher_core_test: FAIL");
			$finish;
		end
	end

endmodule

// ===== files.f =====
hdl/evq_pkg.sv
hdl/evq_ring.sv
hdl/event_queue_dispatcher_core.sv
dv/event_queue_dispatcher_core_test.sv
